>>> rtl/r2b_pkg.sv
// r2b_pkg: shared types, header constants and channel expansion helpers
// for the rgb565 to bmp24 stream encoder; no dependencies
package r2b_pkg;

  localparam int unsigned CfgW    = 13;  // width of the dimension registers
  localparam int unsigned IdxW    = 6;   // byte index within the header
  localparam int unsigned RowW    = 15;  // width of the padded row size in bytes
  localparam int unsigned ImgW    = 28;  // width of the image size in bytes

  localparam logic [IdxW-1:0] HdrLast  = IdxW'(53);  // last header byte
  localparam logic [IdxW-1:0] PixLast  = IdxW'(2);   // last of B, G, R
  localparam logic [31:0]     HdrBytes = 32'd54;
  localparam logic [31:0]     InfoBytes = 32'd40;
  localparam logic [7:0]      BitsPerPixel = 8'd24;
  localparam logic [7:0]      ChrB = 8'h42;
  localparam logic [7:0]      ChrM = 8'h4D;
  localparam logic [7:0]      PlanesLo = 8'd1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_PIX,
    PH_PAD
  } phase_e;

  // c*255/31 rounded down: 8c plus floor(7c/31) by reciprocal
  function automatic logic [7:0] expand5(logic [4:0] c);
    logic [15:0] prod;
    prod = 16'(c) * 16'd1855;
    return {c, 3'b000} | {5'b00000, prod[15:13]};
  endfunction

  // g*255/63 rounded down: 4g plus floor(g/21)
  function automatic logic [7:0] expand6(logic [5:0] g);
    logic [1:0] q;
    if (g >= 6'd63) begin
      q = 2'd3;
    end else if (g >= 6'd42) begin
      q = 2'd2;
    end else if (g >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {g, 2'b00} | {6'b000000, q};
  endfunction

endpackage

>>> rtl/r2b_hdr.sv
// r2b_hdr: bmp header values (row size, image size, file size) and the
// header byte selected by index; uses r2b_pkg
module r2b_hdr (
  input  logic                       clk_i,
  input  logic [r2b_pkg::CfgW-1:0]   width_i,
  input  logic [r2b_pkg::CfgW-1:0]   height_i,
  input  logic [r2b_pkg::IdxW-1:0]   idx_i,
  output logic [7:0]                 byte_o
);

  logic [r2b_pkg::RowW-1:0] row_q, row_d;
  logic [r2b_pkg::ImgW-1:0] img_q, img_d;
  logic [31:0]              fsz_q, fsz_d;
  logic [31:0]              img32;
  logic [31:0]              neg_h;
  logic [31:0]              word;
  logic [1:0]               lane;

  // derived sizes, one register per step; the user keeps dimensions stable while busy (unchecked)
  always_comb begin
    row_d = r2b_pkg::RowW'(17'(width_i) * 17'd3 + 17'd3) & ~r2b_pkg::RowW'(3);
    img_d = r2b_pkg::ImgW'(row_q) * r2b_pkg::ImgW'(height_i);
    fsz_d = 32'(img_q) + r2b_pkg::HdrBytes;
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    img_q <= img_d;
    fsz_q <= fsz_d;
  end

  assign img32 = 32'(img_q);
  assign neg_h = 32'd0 - 32'(height_i);

  always_comb begin
    word = 32'd0;
    lane = 2'd0;
    unique case (idx_i)
      6'd0: word = 32'(r2b_pkg::ChrB);
      6'd1: word = 32'(r2b_pkg::ChrM);
      6'd2, 6'd3, 6'd4, 6'd5: begin
        word = fsz_q;
        lane = 2'(idx_i - 6'd2);
      end
      6'd10, 6'd11, 6'd12, 6'd13: begin
        word = r2b_pkg::HdrBytes;
        lane = 2'(idx_i - 6'd10);
      end
      6'd14, 6'd15, 6'd16, 6'd17: begin
        word = r2b_pkg::InfoBytes;
        lane = 2'(idx_i - 6'd14);
      end
      6'd18, 6'd19, 6'd20, 6'd21: begin
        word = 32'(width_i);
        lane = 2'(idx_i - 6'd18);
      end
      6'd22, 6'd23, 6'd24, 6'd25: begin
        word = neg_h;
        lane = 2'(idx_i - 6'd22);
      end
      6'd26: word = 32'(r2b_pkg::PlanesLo);
      6'd28: word = 32'(r2b_pkg::BitsPerPixel);
      6'd34, 6'd35, 6'd36, 6'd37: begin
        word = img32;
        lane = 2'(idx_i - 6'd34);
      end
      default: word = 32'd0;
    endcase
  end

  assign byte_o = word[{lane, 3'b000} +: 8];

endmodule

>>> rtl/rgb565_to_bmp24_stream_encoder_top.sv
// rgb565_to_bmp24_stream_encoder_top: rgb565 pixels in, 24-bit top-down bmp
// byte stream out; uses r2b_pkg and r2b_hdr
//
// a taken word waits in the pixel register; its bytes leave through the
// output register, one byte per cycle while the receiver is ready: 3 per
// pixel, plus 0..3 pad bytes at row end and 54 header bytes on a frame's
// first pixel; the byte-wide output register sets this. the next pixel is
// taken at the edge that moves the last byte of the current one into the
// output register. reset: counters zero, width 320, height 240, output empty.
module rgb565_to_bmp24_stream_encoder_top #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,

  // pixel input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // pixel_rgb565[15:0]

  // byte output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o    // frame_end[0]
);

  localparam int unsigned CntW = $clog2(MAX_DIMENSION);
  localparam logic [16:0] MaxDim = 17'(MAX_DIMENSION);

  // configuration registers
  logic [r2b_pkg::CfgW-1:0] width_q, height_q;
  logic [r2b_pkg::CfgW-1:0] w_eff, h_eff;

  // raster position
  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;

  // held pixel and what it causes
  logic        item_valid_q, item_valid_d;
  logic [15:0] pix_q;
  logic        row_end_q, last_row_q;
  logic        hdr_now, row_end_now, last_row_now;

  // byte sequencer
  r2b_pkg::phase_e phase_q, phase_d;
  logic [r2b_pkg::IdxW-1:0] idx_q, idx_d;
  logic [1:0]  pad;
  logic        advance, last_byte, in_take;
  logic [7:0]  seq_byte, hdr_byte;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_fend_q;

  function automatic logic [r2b_pkg::CfgW-1:0] clamp_dim(logic [r2b_pkg::CfgW-1:0] v);
    if (v == '0) begin
      return r2b_pkg::CfgW'(1);
    end else if (17'(v) > MaxDim) begin
      return MaxDim[r2b_pkg::CfgW-1:0];
    end else begin
      return v;
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= r2b_pkg::CfgW'(320);
      height_q <= r2b_pkg::CfgW'(240);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        r2b_pkg::RegWidth:  width_q  <= cfg_data_i;
        r2b_pkg::RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(width_q);
  assign h_eff = clamp_dim(height_q);

  // zero bytes after a row: row size rounded to four minus 3*width
  assign pad = 2'(2'd0 - 2'(w_eff[1:0] * 2'd3));

  // decisions for the incoming pixel, taken from the counters now
  assign hdr_now      = (col_q == '0) && (row_q == '0);
  assign row_end_now  = (17'(col_q) + 17'd1) >= 17'(w_eff);
  assign last_row_now = (17'(row_q) + 17'd1) >= 17'(h_eff);

  // sequencer moves when the output register is free or being drained
  assign advance = item_valid_q && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    last_byte = 1'b0;
    unique case (phase_q)
      r2b_pkg::PH_HDR: last_byte = 1'b0;
      r2b_pkg::PH_PIX: last_byte = (idx_q == r2b_pkg::PixLast) &&
                                   !(row_end_q && (pad != 2'd0));
      r2b_pkg::PH_PAD: last_byte = (idx_q == r2b_pkg::IdxW'(pad - 2'd1));
      default:         last_byte = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !item_valid_q || (advance && last_byte);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // raster counters move when a pixel is taken
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_take) begin
      if (row_end_now) begin
        col_d = '0;
        row_d = last_row_now ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  // next phase and byte index
  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    item_valid_d = item_valid_q;
    if (in_take) begin
      item_valid_d = 1'b1;
      phase_d      = hdr_now ? r2b_pkg::PH_HDR : r2b_pkg::PH_PIX;
      idx_d        = '0;
    end else if (advance && last_byte) begin
      item_valid_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + r2b_pkg::IdxW'(1);
      unique case (phase_q)
        r2b_pkg::PH_HDR: begin
          if (idx_q == r2b_pkg::HdrLast) begin
            phase_d = r2b_pkg::PH_PIX;
            idx_d   = '0;
          end
        end
        r2b_pkg::PH_PIX: begin
          if (idx_q == r2b_pkg::PixLast) begin
            phase_d = r2b_pkg::PH_PAD;
            idx_d   = '0;
          end
        end
        r2b_pkg::PH_PAD: ;
        default: ;
      endcase
    end
  end

  // byte for the current phase and index
  always_comb begin
    seq_byte = 8'd0;
    unique case (phase_q)
      r2b_pkg::PH_HDR: seq_byte = hdr_byte;
      r2b_pkg::PH_PIX: begin
        unique case (idx_q[1:0])
          2'd0:    seq_byte = r2b_pkg::expand5(pix_q[4:0]);
          2'd1:    seq_byte = r2b_pkg::expand6(pix_q[10:5]);
          2'd2:    seq_byte = r2b_pkg::expand5(pix_q[15:11]);
          default: seq_byte = 8'd0;
        endcase
      end
      r2b_pkg::PH_PAD: seq_byte = 8'd0;
      default:         seq_byte = 8'd0;
    endcase
  end

  r2b_hdr u_hdr (
    .clk_i    (clk_i),
    .width_i  (w_eff),
    .height_i (h_eff),
    .idx_i    (idx_q),
    .byte_o   (hdr_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      item_valid_q <= 1'b0;
      phase_q      <= r2b_pkg::PH_HDR;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      item_valid_q <= item_valid_d;
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q      <= s_axis_tdata_i;
      row_end_q  <= row_end_now;
      last_row_q <= last_row_now;
    end
    if (advance) begin
      out_byte_q <= seq_byte;
      out_last_q <= last_byte;
      out_fend_q <= last_byte && row_end_q && last_row_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_fend_q;

endmodule

>>> tb/bmp24_byte_checker.sv
// bmp24_byte_checker: follows the register, pixel and byte channels of the
// rgb565 to bmp24 encoder, builds the expected file bytes and compares them
// depends on r2b_pkg for the register width and index codes
module bmp24_byte_checker #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [0:0]               cfg_index_i,
  input  logic [r2b_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     pix_valid_i,
  input  logic                     pix_ready_i,
  input  logic [15:0]              pix_data_i,
  input  logic                     byte_valid_i,
  input  logic                     byte_ready_i,
  input  logic [7:0]               byte_data_i,
  input  logic                     byte_last_i,
  input  logic                     byte_frame_end_i,
  output int unsigned              errors_o,
  output int unsigned              pending_o,
  output int unsigned              pixels_o,
  output int unsigned              bytes_o,
  output int unsigned              frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HEADER_LEN = 32'd54;
  localparam logic [31:0] INFO_LEN   = 32'd40;
  localparam logic [7:0]  PIXEL_BITS = 8'd24;
  localparam int unsigned SHOW_LIMIT = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } bmp_byte_t;

  bmp_byte_t                bmp_bytes_q[$];
  logic [r2b_pkg::CfgW-1:0] width_q;
  logic [r2b_pkg::CfgW-1:0] height_q;
  int unsigned              col_cnt;
  int unsigned              row_cnt;
  int unsigned              shown;

  function automatic int unsigned clamp_dim(logic [r2b_pkg::CfgW-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (32'(v) > MAX_DIMENSION) begin
      return MAX_DIMENSION;
    end
    return 32'(v);
  endfunction

  // channel scaled to 0..255, rounded down
  function automatic logic [7:0] widen(int unsigned c, int unsigned full);
    return 8'((c * 255) / full);
  endfunction

  task automatic push_byte(logic [7:0] b, logic last, logic fend);
    bmp_bytes_q.push_back(bmp_byte_t'{data: b, run_last: last, frame_end: fend});
  endtask

  task automatic push_word(logic [31:0] w);
    push_byte(w[7:0], 1'b0, 1'b0);
    push_byte(w[15:8], 1'b0, 1'b0);
    push_byte(w[23:16], 1'b0, 1'b0);
    push_byte(w[31:24], 1'b0, 1'b0);
  endtask

  // bytes that one pixel causes: header on a frame's first pixel, B G R, row pad
  task automatic encode_pixel(logic [15:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned rb;
    int unsigned pad;
    logic [31:0] img;
    logic        row_end;
    logic        last_row;
    w  = clamp_dim(width_q);
    h  = clamp_dim(height_q);
    rb = (w * 3 + 3) & ~32'd3;
    if (col_cnt == 0 && row_cnt == 0) begin
      img = 32'(rb * h);
      push_byte(8'h42, 1'b0, 1'b0);
      push_byte(8'h4D, 1'b0, 1'b0);
      push_word(img + HEADER_LEN);
      push_word(32'd0);
      push_word(HEADER_LEN);
      push_word(INFO_LEN);
      push_word(32'(w));
      push_word(32'd0 - 32'(h));
      push_byte(8'd1, 1'b0, 1'b0);
      push_byte(8'd0, 1'b0, 1'b0);
      push_byte(PIXEL_BITS, 1'b0, 1'b0);
      push_byte(8'd0, 1'b0, 1'b0);
      push_word(32'd0);
      push_word(img);
      repeat (4) push_word(32'd0);
    end
    row_end  = (col_cnt + 1 >= w);
    last_row = (row_cnt + 1 >= h);
    pad      = row_end ? rb - w * 3 : 0;
    push_byte(widen(32'(px[4:0]), 31), 1'b0, 1'b0);
    push_byte(widen(32'(px[10:5]), 63), 1'b0, 1'b0);
    push_byte(widen(32'(px[15:11]), 31), pad == 0, row_end && last_row && pad == 0);
    for (int unsigned i = 1; i <= pad; i++) begin
      push_byte(8'h00, i == pad, i == pad && last_row);
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    pixels_o++;
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    errors_o++;
    if (shown < SHOW_LIMIT) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      shown++;
    end
  endtask

  task automatic check_byte();
    bmp_byte_t want;
    bytes_o++;
    if (byte_frame_end_i) begin
      frames_o++;
    end
    if (bmp_bytes_q.size() == 0) begin
      errors_o++;
      if (shown < SHOW_LIMIT) begin
        $display("%0t: word %0h arrived, expected none", $time, byte_data_i);
        shown++;
      end
    end else begin
      want = bmp_bytes_q.pop_front();
      if (byte_data_i !== want.data) begin
        note_mismatch("out_byte", 32'(want.data), 32'(byte_data_i));
      end
      if (byte_last_i !== want.run_last) begin
        note_mismatch("run_last", 32'(want.run_last), 32'(byte_last_i));
      end
      if (byte_frame_end_i !== want.frame_end) begin
        note_mismatch("frame_end", 32'(want.frame_end), 32'(byte_frame_end_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmp_bytes_q.delete();
      width_q   = 13'd320;
      height_q  = 13'd240;
      col_cnt   = 0;
      row_cnt   = 0;
      shown     = 0;
      errors_o  = 0;
      pending_o = 0;
      pixels_o  = 0;
      bytes_o   = 0;
      frames_o  = 0;
    end else begin
      // older expectations are consumed before this edge's pixel adds new ones
      if (byte_valid_i && byte_ready_i) begin
        check_byte();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == r2b_pkg::RegWidth) begin
          width_q = cfg_data_i;
        end else begin
          height_q = cfg_data_i;
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        encode_pixel(pix_data_i);
      end
      pending_o = bmp_bytes_q.size();
    end
  end

endmodule

>>> tb/rgb565_to_bmp24_stream_encoder_top_test.sv
// rgb565_to_bmp24_stream_encoder_top_test: drives pixels and register writes
// into the encoder, stalls both sides at random and gives the verdict
// depends on r2b_pkg, the encoder top and bmp24_byte_checker
module rgb565_to_bmp24_stream_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned ITEMS        = 430;   // pixels to send in total
  localparam int unsigned CALM_ITEMS   = 60;    // closing stretch with no idling
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no word moving
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                     clk;
  logic                     rst_n;

  // register write channel
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [0:0]               cfg_index;
  logic [r2b_pkg::CfgW-1:0] cfg_data;

  // pixel side
  logic                     pix_valid;
  logic                     pix_ready;
  logic [15:0]              pix_data;

  // byte side
  logic                     byte_valid;
  logic                     byte_ready;
  logic [7:0]               byte_data;
  logic                     byte_last;
  logic                     byte_frame_end;

  int unsigned              errors;
  int unsigned              pending;
  int unsigned              pixels_seen;
  int unsigned              bytes_seen;
  int unsigned              frames_seen;

  // shared between the sender, the receiver and the stimulus flow
  int unsigned              src_pct;      // chance of a gap before a pixel
  int unsigned              sink_pct;     // chance of a stall burst on the byte side
  logic                     calm;         // closing stretch: nobody idles
  logic                     hold_req;     // asks the receiver for a long hold-off
  int unsigned              pixels_sent;
  int unsigned              reg_writes;

  rgb565_to_bmp24_stream_encoder_top #(
    .MAX_DIMENSION(MAX_DIM)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(pix_valid),
    .s_axis_tready_o(pix_ready),
    .s_axis_tdata_i (pix_data),
    .m_axis_tvalid_o(byte_valid),
    .m_axis_tready_i(byte_ready),
    .m_axis_tdata_o (byte_data),
    .m_axis_tlast_o (byte_last),
    .m_axis_tuser_o (byte_frame_end)
  );

  bmp24_byte_checker #(
    .MAX_DIMENSION(MAX_DIM)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pix_valid_i     (pix_valid),
    .pix_ready_i     (pix_ready),
    .pix_data_i      (pix_data),
    .byte_valid_i    (byte_valid),
    .byte_ready_i    (byte_ready),
    .byte_data_i     (byte_data),
    .byte_last_i     (byte_last),
    .byte_frame_end_i(byte_frame_end),
    .errors_o        (errors),
    .pending_o       (pending),
    .pixels_o        (pixels_seen),
    .bytes_o         (bytes_seen),
    .frames_o        (frames_seen)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // share of cycles spent idling for the next phase, none now and then
  function automatic int unsigned idle_share();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // mostly random pixels, with the all-zero and all-one words mixed in
  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one pixel word, maybe after a gap with valid low; returns once taken
  task automatic send_pixel(input logic [15:0] px);
    int unsigned gap;
    if (!calm && src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_data  <= px;
    do @(posedge clk); while (!pix_ready);
    pixels_sent++;
    if (pixels_sent >= ITEMS - CALM_ITEMS) begin
      calm = 1'b1;
    end
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_pixel(rand_pixel());
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= r2b_pkg::CfgW'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // stop offering pixels and wait until every expected byte has left
  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // the last byte may still be leaving the output register
    repeat (4) @(negedge clk);
  endtask

  // registers change only with the encoder idle; counters carry over
  task automatic set_dims(input int unsigned w, input int unsigned h);
    drain();
    write_reg(r2b_pkg::RegWidth, w);
    write_reg(r2b_pkg::RegHeight, h);
  endtask

  // receiver: random stall bursts, a long hold-off on request, none at the end
  initial begin : byte_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    byte_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        byte_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        byte_ready <= 1'b1;
      end else if (stall_left != 0) begin
        byte_ready <= 1'b0;
        stall_left--;
      end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        byte_ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        byte_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any word moving on any channel ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pix_valid && pix_ready) || (byte_valid && byte_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: %0d cycles with no word moving, %0d bytes outstanding",
             QUIET_LIMIT, pending);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned n;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = r2b_pkg::RegWidth;
    cfg_data    = '0;
    pix_valid   = 1'b0;
    pix_data    = '0;
    src_pct     = 0;
    sink_pct    = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    pixels_sent = 0;
    reg_writes  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset dimensions 320 x 240: header carries them, then black and white
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);

    // zero width and height act as 1 x 1: the first pixel closes the open
    // frame, each later one is a whole file with header and one pad byte;
    // pure red, green, blue and the lowest step
    set_dims(0, 0);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'h0821);

    // all-ones registers act as the maximum dimension, seen in the header
    set_dims(8191, 8191);
    send_pixel(16'h8410);
    send_pixel(16'h7BEF);
    send_pixel(16'hAAAA);

    // just above the maximum, changed mid-frame
    set_dims(MAX_DIM + 1, MAX_DIM + 1);
    send_pixel(16'h5555);
    send_pixel(rand_pixel());

    // shrink mid-frame: column already past the new width ends the row at once
    src_pct  = 25;
    sink_pct = 25;
    set_dims(2, 3);
    send_random(5);

    // three-pixel rows pad by three, four-pixel rows need no pad
    set_dims(3, 1);
    send_random(3);
    set_dims(4, 1);
    send_random(4);

    // back pressure: receiver holds off while the sender keeps offering
    src_pct  = 0;
    sink_pct = 0;
    set_dims(5, 2);
    hold_req = 1'b1;
    send_random(30);

    // random phases: mostly complete small frames, some cut short,
    // now and then huge or out-of-range registers with a few pixels
    while (pixels_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 8191);
        h = $urandom_range(0, 8191);
        n = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 4);
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) begin
          n += $urandom_range(1, 3);
        end
        if (n > 40) begin
          n = 40;
        end
      end
      src_pct  = idle_share();
      sink_pct = idle_share();
      set_dims(w, h);
      send_random(n);
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d pixels (%0d taken) and %0d register writes, checked %0d output words",
             pixels_sent, pixels_seen, reg_writes, bytes_seen);
    $display("%0d frame ends seen, %0d mismatches", frames_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
